>>> rtl/core/ssc_pkg.sv
// Shared types and constants for the sphere-sphere contact block.
`default_nettype none
package ssc_pkg;
    localparam int CW         = 32;   // coordinate width, Q16.16
    localparam int RW         = 31;   // radius width
    localparam int NF         = 30;   // normal fraction bits, Q2.30
    localparam int SQ_STAGES  = 32;   // one root bit per stage
    localparam int DIV_STAGES = 31;   // one quotient bit per stage
    localparam int QW         = 4;    // queue depth
    localparam int QAW        = $clog2(QW);

    // Classified item handed from the front end to the back end.
    typedef struct packed {
        logic [2:0][CW-1:0] ca;
        logic [2:0][CW-1:0] cb;
        logic [RW-1:0]      ra;
        logic [RW-1:0]      rb;
        logic [2:0][CW-1:0] mag;
        logic [2:0]         neg;
        logic [63:0]        dsq;
        logic               ovl;
    } t_item;

    // Context carried behind the square root.
    typedef struct packed {
        logic [2:0][CW-1:0] ca;
        logic [2:0][CW-1:0] cb;
        logic [RW-1:0]      ra;
        logic [RW-1:0]      rb;
        logic [2:0]         neg;
        logic               hit;
        logic [CW-1:0]      depth;
        logic [CW-1:0]      span;
    } t_ctx;
endpackage
`default_nettype wire

>>> rtl/core/sphere_sphere_contact_top.sv
// Path: front end, queue, square-root stages, hit decision, division stages, multiply
// and output register. Throughput: one sphere pair per cycle unless i_ready stalls,
// set by the fully pipelined root and divider.
// Reset (synchronous, active low) empties every stage and the queue and sets the
// minimum center distance to 1; it takes effect at the next clock edge.
`default_nettype none
module sphere_sphere_contact_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [31:0] i_center_a_x,
    input  wire logic [31:0] i_center_a_y,
    input  wire logic [31:0] i_center_a_z,
    input  wire logic [30:0] i_radius_a,
    input  wire logic [31:0] i_center_b_x,
    input  wire logic [31:0] i_center_b_y,
    input  wire logic [31:0] i_center_b_z,
    input  wire logic [30:0] i_radius_b,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic             o_hit,
    output logic [31:0]      o_depth,
    output logic [31:0]      o_normal_x,
    output logic [31:0]      o_normal_y,
    output logic [31:0]      o_normal_z,
    output logic [31:0]      o_point_a_x,
    output logic [31:0]      o_point_a_y,
    output logic [31:0]      o_point_a_z,
    output logic [31:0]      o_point_b_x,
    output logic [31:0]      o_point_b_y,
    output logic [31:0]      o_point_b_z
);
    logic [15:0] r_min_dist;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)      r_min_dist <= 16'd1;
        else if (i_cfg_we) r_min_dist <= i_cfg_data;
    end

    logic           f_valid, q_ready, q_valid, b_ready;
    ssc_pkg::t_item f_item, q_item;
    logic [2:0][31:0] nrm, pa, pb;

    ssc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_ca      ({i_center_a_z, i_center_a_y, i_center_a_x}),
        .i_cb      ({i_center_b_z, i_center_b_y, i_center_b_x}),
        .i_ra      (i_radius_a),
        .i_rb      (i_radius_b),
        .o_valid   (f_valid),
        .i_q_ready (q_ready),
        .o_item    (f_item)
    );

    ssc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (q_ready),
        .i_item  (f_item),
        .o_valid (q_valid),
        .i_ready (b_ready),
        .o_item  (q_item)
    );

    ssc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_min_dist (r_min_dist),
        .i_valid    (q_valid),
        .o_ready    (b_ready),
        .i_item     (q_item),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_hit      (o_hit),
        .o_depth    (o_depth),
        .o_normal   (nrm),
        .o_point_a  (pa),
        .o_point_b  (pb)
    );

    assign o_normal_x  = nrm[0];
    assign o_normal_y  = nrm[1];
    assign o_normal_z  = nrm[2];
    assign o_point_a_x = pa[0];
    assign o_point_a_y = pa[1];
    assign o_point_a_z = pa[2];
    assign o_point_b_x = pb[0];
    assign o_point_b_y = pb[1];
    assign o_point_b_z = pb[2];
endmodule
`default_nettype wire

>>> rtl/core/ssc_front.sv
// Front end: takes sphere pairs, forms offsets, squares and the overlap flag.
`default_nettype none
module ssc_front (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire logic [2:0][ssc_pkg::CW-1:0] i_ca,
    input  wire logic [2:0][ssc_pkg::CW-1:0] i_cb,
    input  wire logic [ssc_pkg::RW-1:0]    i_ra,
    input  wire logic [ssc_pkg::RW-1:0]    i_rb,
    output logic                           o_valid,
    input  wire logic                      i_q_ready,
    output ssc_pkg::t_item                 o_item
);
    logic r_v1, r_v2, r_v3;
    logic adv;

    logic [2:0][ssc_pkg::CW-1:0] r1_ca, r1_cb, r2_ca, r2_cb;
    logic [ssc_pkg::RW-1:0]      r1_ra, r1_rb, r2_ra, r2_rb;
    logic [2:0][32:0]            r1_mag, n_mag;
    logic [2:0]                  r1_neg, r2_neg, n_neg;
    logic [ssc_pkg::CW-1:0]      r1_sep;
    logic [2:0][64:0]            r2_sq;
    logic [63:0]                 r2_sep2;
    logic [2:0][ssc_pkg::CW-1:0] r2_mag;
    logic [65:0]                 dsq;
    ssc_pkg::t_item              r_item;

    assign adv     = !r_v3 || i_q_ready;
    assign o_ready = adv;
    assign o_valid = r_v3;
    assign o_item  = r_item;

    always_comb begin
        logic signed [32:0] d;
        for (int k = 0; k < 3; k++) begin
            d = $signed({i_cb[k][31], i_cb[k]}) - $signed({i_ca[k][31], i_ca[k]});
            n_neg[k] = d[32];
            n_mag[k] = d[32] ? 33'(-d) : 33'(d);
        end
    end

    assign dsq = {1'b0, r2_sq[0]} + {1'b0, r2_sq[1]} + {1'b0, r2_sq[2]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (adv) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_ca  <= i_ca;
            r1_cb  <= i_cb;
            r1_ra  <= i_ra;
            r1_rb  <= i_rb;
            r1_mag <= n_mag;
            r1_neg <= n_neg;
            r1_sep <= {1'b0, i_ra} + {1'b0, i_rb};

            r2_ca   <= r1_ca;
            r2_cb   <= r1_cb;
            r2_ra   <= r1_ra;
            r2_rb   <= r1_rb;
            r2_neg  <= r1_neg;
            r2_sep2 <= r1_sep * r1_sep;
            for (int k = 0; k < 3; k++) begin
                r2_sq[k]  <= 65'(r1_mag[k] * r1_mag[k]);
                r2_mag[k] <= r1_mag[k][31:0];
            end

            r_item.ca  <= r2_ca;
            r_item.cb  <= r2_cb;
            r_item.ra  <= r2_ra;
            r_item.rb  <= r2_rb;
            r_item.mag <= r2_mag;
            r_item.neg <= r2_neg;
            r_item.dsq <= dsq[63:0];
            r_item.ovl <= dsq < {2'b0, r2_sep2};
        end
    end
endmodule
`default_nettype wire

>>> rtl/core/ssc_queue.sv
// Short queue between the front end and the back end.
`default_nettype none
module ssc_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire ssc_pkg::t_item i_item,
    output logic                o_valid,
    input  wire logic           i_ready,
    output ssc_pkg::t_item      o_item
);
    ssc_pkg::t_item r_mem [ssc_pkg::QW];
    logic [ssc_pkg::QAW-1:0] r_wr, r_rd;
    logic [ssc_pkg::QAW:0]   r_cnt;
    logic push, pop;

    assign o_ready = r_cnt != (ssc_pkg::QAW+1)'(ssc_pkg::QW);
    assign o_valid = r_cnt != '0;
    assign o_item  = r_mem[r_rd];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wr <= r_wr + 1'b1;
            if (pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (ssc_pkg::QAW+1)'(push) - (ssc_pkg::QAW+1)'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wr] <= i_item;
    end
endmodule
`default_nettype wire

>>> rtl/core/ssc_back.sv
// Back end: square root, normal division, surface offsets and output register.
`default_nettype none
module ssc_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic [15:0]    i_min_dist,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire ssc_pkg::t_item i_item,
    output logic                o_valid,
    input  wire logic           i_ready,
    output logic                o_hit,
    output logic [31:0]         o_depth,
    output logic [2:0][31:0]    o_normal,
    output logic [2:0][31:0]    o_point_a,
    output logic [2:0][31:0]    o_point_b
);
    localparam int SQ = ssc_pkg::SQ_STAGES;
    localparam int DV = ssc_pkg::DIV_STAGES;

    logic en;
    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    // square root, one bit per stage
    logic           r_sv  [SQ];
    ssc_pkg::t_item r_sit [SQ];
    logic [31:0]    r_root[SQ], n_root[SQ];
    logic [63:0]    r_rem [SQ], n_rem [SQ];

    always_comb begin
        logic [31:0] root;
        logic [63:0] rem, t;
        for (int s = 0; s < SQ; s++) begin
            root = (s == 0) ? 32'd0 : r_root[(s == 0) ? 0 : s-1];
            rem  = (s == 0) ? i_item.dsq : r_rem[(s == 0) ? 0 : s-1];
            t = ({32'd0, root} << (SQ - s)) | (64'd1 << (2 * (SQ - 1 - s)));
            if (rem >= t) begin
                n_rem[s]  = rem - t;
                n_root[s] = root | (32'd1 << (SQ - 1 - s));
            end else begin
                n_rem[s]  = rem;
                n_root[s] = root;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < SQ; s++) r_sv[s] <= 1'b0;
        end else if (en) begin
            r_sv[0] <= i_valid;
            for (int s = 1; s < SQ; s++) r_sv[s] <= r_sv[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sit[0] <= i_item;
            for (int s = 1; s < SQ; s++) r_sit[s] <= r_sit[s-1];
            for (int s = 0; s < SQ; s++) begin
                r_root[s] <= n_root[s];
                r_rem[s]  <= n_rem[s];
            end
        end
    end

    // hit decision and dividends
    logic                 r_pv;
    ssc_pkg::t_ctx        r_pc;
    logic [2:0][62:0]     r_pn;
    ssc_pkg::t_item       last;
    logic [31:0]          span;
    assign last = r_sit[SQ-1];
    assign span = r_root[SQ-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_pv <= 1'b0;
        else if (en)  r_pv <= r_sv[SQ-1];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pc.ca    <= last.ca;
            r_pc.cb    <= last.cb;
            r_pc.ra    <= last.ra;
            r_pc.rb    <= last.rb;
            r_pc.neg   <= last.neg;
            r_pc.hit   <= last.ovl && (span > {16'd0, i_min_dist});
            r_pc.depth <= 32'({1'b0, last.ra} + {1'b0, last.rb} - span);
            r_pc.span  <= span;
            for (int k = 0; k < 3; k++)
                r_pn[k] <= {1'b0, last.mag[k], 30'd0} + {32'd0, span[31:1]};
        end
    end

    // restoring division, one quotient bit per stage
    logic                 r_dv [DV];
    ssc_pkg::t_ctx        r_dc [DV];
    logic [2:0][62:0]     r_dr [DV], n_dr [DV];
    logic [2:0][30:0]     r_dq [DV], n_dq [DV];

    always_comb begin
        logic [62:0] rem, t;
        logic [30:0] q;
        logic [31:0] d;
        for (int j = 0; j < DV; j++) begin
            d = (j == 0) ? r_pc.span : r_dc[(j == 0) ? 0 : j-1].span;
            t = {31'd0, d} << (DV - 1 - j);
            for (int k = 0; k < 3; k++) begin
                rem = (j == 0) ? r_pn[k] : r_dr[(j == 0) ? 0 : j-1][k];
                q   = (j == 0) ? 31'd0 : r_dq[(j == 0) ? 0 : j-1][k];
                if (rem >= t) begin
                    n_dr[j][k] = rem - t;
                    n_dq[j][k] = q | (31'd1 << (DV - 1 - j));
                end else begin
                    n_dr[j][k] = rem;
                    n_dq[j][k] = q;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < DV; j++) r_dv[j] <= 1'b0;
        end else if (en) begin
            r_dv[0] <= r_pv;
            for (int j = 1; j < DV; j++) r_dv[j] <= r_dv[j-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dc[0] <= r_pc;
            for (int j = 1; j < DV; j++) r_dc[j] <= r_dc[j-1];
            for (int j = 0; j < DV; j++) begin
                r_dr[j] <= n_dr[j];
                r_dq[j] <= n_dq[j];
            end
        end
    end

    // surface offsets
    logic             r_mv;
    ssc_pkg::t_ctx    r_mc;
    logic [2:0][30:0] r_mq;
    logic [2:0][61:0] r_pa, r_pb;
    logic [2:0][30:0] qc;

    always_comb begin
        for (int k = 0; k < 3; k++)
            qc[k] = (r_dq[DV-1][k] > (31'd1 << ssc_pkg::NF)) ? (31'd1 << ssc_pkg::NF)
                                                           : r_dq[DV-1][k];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_mv <= 1'b0;
        else if (en)  r_mv <= r_dv[DV-1];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mc <= r_dc[DV-1];
            r_mq <= qc;
            for (int k = 0; k < 3; k++) begin
                r_pa[k] <= qc[k] * r_dc[DV-1].ra;
                r_pb[k] <= qc[k] * r_dc[DV-1].rb;
            end
        end
    end

    // contact points, saturation and output register
    function automatic logic [31:0] sat32(input logic signed [34:0] v);
        if (v > 35'sd2147483647)       return 32'h7FFF_FFFF;
        else if (v < -35'sd2147483648) return 32'h8000_0000;
        else                           return v[31:0];
    endfunction

    logic [2:0][31:0] n_nrm, n_pa, n_pb;

    always_comb begin
        logic [62:0]        sa, sb;
        logic signed [34:0] ca, cb, oa, ob;
        for (int k = 0; k < 3; k++) begin
            sa = {1'b0, r_pa[k]} + (63'd1 << (ssc_pkg::NF - 1));
            sb = {1'b0, r_pb[k]} + (63'd1 << (ssc_pkg::NF - 1));
            oa = $signed({2'b0, sa[62:30]});
            ob = $signed({2'b0, sb[62:30]});
            ca = $signed({{3{r_mc.ca[k][31]}}, r_mc.ca[k]});
            cb = $signed({{3{r_mc.cb[k][31]}}, r_mc.cb[k]});
            n_nrm[k] = r_mc.neg[k] ? 32'(-{1'b0, r_mq[k]}) : {1'b0, r_mq[k]};
            n_pa[k]  = sat32(r_mc.neg[k] ? ca - oa : ca + oa);
            n_pb[k]  = sat32(r_mc.neg[k] ? cb + ob : cb - ob);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else if (en)  o_valid <= r_mv;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_hit     <= r_mc.hit;
            o_depth   <= r_mc.hit ? r_mc.depth : 32'd0;
            o_normal  <= r_mc.hit ? n_nrm : '0;
            o_point_a <= r_mc.hit ? n_pa  : '0;
            o_point_b <= r_mc.hit ? n_pb  : '0;
        end
    end
endmodule
`default_nettype wire

>>> sim/ssc_checker.sv
// Checker for the sphere-sphere contact block: watches both channels, predicts and compares.
`timescale 1ns / 100ps
`default_nettype none
module ssc_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_valid,
    input  wire logic        i_in_ready,
    input  wire logic [31:0] i_cax, i_cay, i_caz,
    input  wire logic [30:0] i_ra,
    input  wire logic [31:0] i_cbx, i_cby, i_cbz,
    input  wire logic [30:0] i_rb,
    input  wire logic        i_out_valid,
    input  wire logic        i_ready,
    input  wire logic        i_hit,
    input  wire logic [31:0] i_depth,
    input  wire logic [31:0] i_nx, i_ny, i_nz,
    input  wire logic [31:0] i_pax, i_pay, i_paz,
    input  wire logic [31:0] i_pbx, i_pby, i_pbz,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_hit_count,
    output int               o_result_count
);
    typedef struct {
        logic        hit;
        logic [31:0] depth;
        logic [31:0] n [3];
        logic [31:0] pa [3];
        logic [31:0] pb [3];
    } t_contact;

    t_contact    contact_q [$];
    logic [15:0] min_dist;

    function automatic logic [63:0] isqrt128(logic [127:0] n);
        logic [63:0]  r;
        logic [63:0]  c;
        r = 0;
        for (int b = 63; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if (128'(c) * 128'(c) <= n) r = c;
        end
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(logic signed [65:0] v);
        if (v > 66'sd2147483647) return 32'sh7fffffff;
        if (v < -66'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic t_contact contact_of(logic [31:0] ca [3], logic [31:0] cb [3],
                                             logic [30:0] ra, logic [30:0] rb,
                                             logic [15:0] mind);
        t_contact     r;
        logic signed [33:0] d;
        logic [32:0]  mag [3];
        logic         neg [3];
        logic [127:0] dsq;
        logic [63:0]  sep;
        logic [63:0]  span;
        logic [127:0] q;
        logic [127:0] off;
        logic signed [65:0] sa;
        logic signed [65:0] sb;
        dsq = 0;
        for (int k = 0; k < 3; k++) begin
            d = $signed({cb[k][31], cb[k]}) - $signed({ca[k][31], ca[k]});
            neg[k] = d < 0;
            mag[k] = neg[k] ? 33'(-d) : 33'(d);
            dsq += 128'(mag[k]) * 128'(mag[k]);
        end
        sep = 64'(ra) + 64'(rb);
        span = isqrt128(dsq);
        r.hit = 0;
        r.depth = 0;
        for (int k = 0; k < 3; k++) begin
            r.n[k] = 0; r.pa[k] = 0; r.pb[k] = 0;
        end
        if (dsq >= 128'(sep) * 128'(sep) || span <= 64'(mind)) return r;
        r.hit = 1;
        r.depth = 32'(sep - span);
        for (int k = 0; k < 3; k++) begin
            q = ((128'(mag[k]) << 30) + 128'(span >> 1)) / 128'(span);
            if (q > (128'd1 << 30)) q = 128'd1 << 30;
            r.n[k] = neg[k] ? -32'(q) : 32'(q);
            off = (q * 128'(ra) + (128'd1 << 29)) >> 30;
            sa = neg[k] ? $signed(66'($signed(ca[k]))) - $signed({2'b0, 64'(off)})
                        : $signed(66'($signed(ca[k]))) + $signed({2'b0, 64'(off)});
            off = (q * 128'(rb) + (128'd1 << 29)) >> 30;
            sb = neg[k] ? $signed(66'($signed(cb[k]))) + $signed({2'b0, 64'(off)})
                        : $signed(66'($signed(cb[k]))) - $signed({2'b0, 64'(off)});
            r.pa[k] = sat32(sa);
            r.pb[k] = sat32(sb);
        end
        return r;
    endfunction

    task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %h, got %h", name, want, got);
            o_fail_count++;
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_pending = 0;
        o_hit_count = 0;
        o_result_count = 0;
        min_dist = 16'd1;
    end

    always @(posedge i_clk) begin
        t_contact    e;
        logic [31:0] ca [3];
        logic [31:0] cb [3];
        if (!i_rst_n) begin
            min_dist <= 16'd1;
        end else begin
            if (i_cfg_we) min_dist <= i_cfg_data;
            if (i_valid && i_in_ready) begin
                ca = '{i_cax, i_cay, i_caz};
                cb = '{i_cbx, i_cby, i_cbz};
                contact_q.insert(contact_q.size(), contact_of(ca, cb, i_ra, i_rb, min_dist));
            end
            if (i_out_valid && i_ready) begin
                o_result_count++;
                if (contact_q.size() == 0) begin
                    $error("result with no item outstanding");
                    o_fail_count++;
                end else begin
                    e = contact_q.pop_front();
                    if (e.hit) o_hit_count++;
                    compare_field("hit", 32'(e.hit), 32'(i_hit));
                    compare_field("depth", e.depth, i_depth);
                    compare_field("normal_x", e.n[0], i_nx);
                    compare_field("normal_y", e.n[1], i_ny);
                    compare_field("normal_z", e.n[2], i_nz);
                    compare_field("point_a_x", e.pa[0], i_pax);
                    compare_field("point_a_y", e.pa[1], i_pay);
                    compare_field("point_a_z", e.pa[2], i_paz);
                    compare_field("point_b_x", e.pb[0], i_pbx);
                    compare_field("point_b_y", e.pb[1], i_pby);
                    compare_field("point_b_z", e.pb[2], i_pbz);
                end
            end
        end
        o_pending = contact_q.size();
    end
endmodule
`default_nettype wire

>>> sim/testbench.sv
// Stimulus and verdict for the sphere-sphere contact block.
`timescale 1ns / 100ps
`default_nettype none
module testbench;
    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] cax, cay, caz, cbx, cby, cbz;
    logic [30:0] ra, rb;
    logic        out_valid;
    logic        out_ready;
    logic        hit;
    logic [31:0] depth, nx, ny, nz, pax, pay, paz, pbx, pby, pbz;
    int          fail_count, pending, hit_count, result_count;
    int          send_idle_pct, recv_idle_pct;
    int          hold_cycles;
    int          cycle_count;
    int          sent;

    sphere_sphere_contact_top dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_data(cfg_data),
        .i_valid(in_valid), .o_ready(in_ready),
        .i_center_a_x(cax), .i_center_a_y(cay), .i_center_a_z(caz), .i_radius_a(ra),
        .i_center_b_x(cbx), .i_center_b_y(cby), .i_center_b_z(cbz), .i_radius_b(rb),
        .o_valid(out_valid), .i_ready(out_ready),
        .o_hit(hit), .o_depth(depth),
        .o_normal_x(nx), .o_normal_y(ny), .o_normal_z(nz),
        .o_point_a_x(pax), .o_point_a_y(pay), .o_point_a_z(paz),
        .o_point_b_x(pbx), .o_point_b_y(pby), .o_point_b_z(pbz)
    );

    ssc_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_data(cfg_data),
        .i_valid(in_valid), .i_in_ready(in_ready),
        .i_cax(cax), .i_cay(cay), .i_caz(caz), .i_ra(ra),
        .i_cbx(cbx), .i_cby(cby), .i_cbz(cbz), .i_rb(rb),
        .i_out_valid(out_valid), .i_ready(out_ready),
        .i_hit(hit), .i_depth(depth), .i_nx(nx), .i_ny(ny), .i_nz(nz),
        .i_pax(pax), .i_pay(pay), .i_paz(paz), .i_pbx(pbx), .i_pby(pby), .i_pbz(pbz),
        .o_fail_count(fail_count), .o_pending(pending),
        .o_hit_count(hit_count), .o_result_count(result_count)
    );

    initial begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    // Receiver: random stall, or a long hold-off when requested.
    always @(posedge clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("testbench failed");
            $finish;
        end
    end

    // Offer one pair and hold it until accepted; drop valid only while idling.
    task automatic send_pair(logic [31:0] a_x, a_y, a_z, logic [30:0] r_a,
                             logic [31:0] b_x, b_y, b_z, logic [30:0] r_b);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        cax <= a_x; cay <= a_y; caz <= a_z; ra <= r_a;
        cbx <= b_x; cby <= b_y; cbz <= b_z; rb <= r_b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sent++;
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic write_min_dist(logic [15:0] v);
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Mostly overlapping pairs of assorted scale; some fully random noise.
    task automatic random_pair;
        logic [31:0] a [3];
        logic [31:0] b [3];
        logic [30:0] r_a, r_b;
        int          sh;
        int          kind;
        kind = $urandom_range(9);
        sh = $urandom_range(30, 4);
        for (int k = 0; k < 3; k++) begin
            a[k] = $urandom;
            if (kind < 7) a[k] = $signed(a[k]) >>> $urandom_range(12);
            b[k] = (kind < 7) ? a[k] + ($signed($urandom) >>> (32 - sh)) : $urandom;
        end
        r_a = (kind < 7) ? 31'($urandom) >> (31 - sh) : 31'($urandom);
        r_b = (kind < 7) ? 31'($urandom) >> (31 - sh) : 31'($urandom);
        if (kind == 9) begin
            r_a = 31'h7fffffff - 31'($urandom_range(255));
            r_b = 31'($urandom);
        end
        send_pair(a[0], a[1], a[2], r_a, b[0], b[1], b[2], r_b);
    endtask

    initial begin
        logic [15:0] settings [4];
        rst_n = 0; cfg_we = 0; cfg_data = 0; in_valid = 0;
        cax = 0; cay = 0; caz = 0; cbx = 0; cby = 0; cbz = 0; ra = 0; rb = 0;
        out_ready = 0; hold_cycles = 0; cycle_count = 0; sent = 0;
        send_idle_pct = 0; recv_idle_pct = 0;
        settings = '{16'd0, 16'hffff, 16'd300, 16'd1};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: overlap along each axis, touching, coincident, extremes.
        send_pair(0, 0, 0, 31'h10000, 32'h18000, 0, 0, 31'h10000);
        send_pair(0, 0, 0, 31'h10000, 0, 32'hfffe8000, 0, 31'h10000);
        send_pair(0, 0, 0, 31'h10000, 0, 0, 32'h8000, 31'h20000);
        send_pair(0, 0, 0, 31'h10000, 32'h20000, 0, 0, 31'h10000);
        send_pair(5, 5, 5, 31'h10000, 5, 5, 5, 31'h10000);
        send_pair(0, 0, 0, 31'h10000, 1, 0, 0, 31'h10000);
        send_pair(0, 0, 0, 31'h10000, 1, 1, 1, 31'h10000);
        send_pair(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 31'h7fffffff,
                  32'h80000000, 32'h80000000, 32'h80000000, 31'h7fffffff);
        send_pair(32'h80000000, 0, 32'h7fffffff, 31'h7fffffff,
                  32'h7fffffff, 32'h80000000, 32'h80000000, 31'h7fffffff);
        send_pair(32'h7fff0000, 0, 0, 31'h7fffffff, 32'h7ff00000, 0, 0, 31'h7fffffff);
        send_pair(32'h12345, 32'hfff00000, 32'h40000, 31'h55555,
                  32'h23456, 32'hfff10000, 32'h30000, 31'h2aaaa);
        send_pair(0, 0, 0, 31'h0, 3, 4, 0, 31'h0);
        send_pair(0, 0, 0, 31'h7fffffff, 32'h7fffffff, 0, 0, 31'h0);
        drain();

        // Phase 1 with a long receiver hold-off so the pipeline fills.
        send_idle_pct = 12; recv_idle_pct = 45;
        hold_cycles = 300;
        for (int i = 0; i < 150; i++) random_pair();
        for (int p = 0; p < 4; p++) begin
            drain();
            write_min_dist(settings[p]);
            if (p == 1) begin
                send_idle_pct = 45; recv_idle_pct = 12;
            end else if (p == 2) begin
                send_idle_pct = 0; recv_idle_pct = 0;
            end
            for (int i = 0; i < 75; i++) random_pair();
            // Near-coincident centers around the threshold.
            for (int i = 0; i < 5; i++)
                send_pair(0, 0, 0, 31'h10000, 32'($urandom_range(70000)), 0, 0, 31'h10000);
        end
        drain();

        $display("sent %0d pairs, %0d results checked, %0d contacts reported",
                 sent, result_count, hit_count);
        $display("thresholds 0, 1, 300 and 65535 with varied back pressure");
        if (fail_count == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
